// ===== rtl/core/plfe_pkg.sv =====
// ----------------------------------------------------------------------------
// plfe_pkg - shared definitions for the Playfair digraph encryptor
// Square geometry, input mode codes, the front-to-back command word and the
// letter folding and cell geometry functions.
// ----------------------------------------------------------------------------
package plfe_pkg;

	localparam int SQUARE_SIDE = 5;
	localparam int CELLS       = SQUARE_SIDE * SQUARE_SIDE;
	localparam int CELL_W      = $clog2(CELLS);
	localparam int ROW_W       = $clog2(SQUARE_SIDE);
	localparam int LETTERS     = 26;
	localparam int LETTER_W    = $clog2(LETTERS);
	localparam int FILL_W      = $clog2(CELLS + 1);

	localparam int QUEUE_DEPTH = 4;
	localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
	localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

	typedef logic [LETTER_W-1:0] letter_t;
	typedef logic [CELL_W-1:0]   cell_t;
	typedef logic [ROW_W-1:0]    coord_t;

	localparam letter_t IDX_I = letter_t'(8);
	localparam letter_t IDX_J = letter_t'(9);
	localparam letter_t IDX_X = letter_t'(23);

	localparam logic [1:0] MODE_KEY  = 2'd0;
	localparam logic [1:0] MODE_DONE = 2'd1;
	localparam logic [1:0] MODE_TEXT = 2'd2;
	localparam logic [1:0] MODE_END  = 2'd3;

	localparam logic CMD_PLACE = 1'b0;
	localparam logic CMD_PAIR  = 1'b1;

	localparam logic [7:0] ASCII_UPPER_A = 8'h41;
	localparam logic [7:0] ASCII_UPPER_Z = 8'h5A;
	localparam logic [7:0] ASCII_LOWER_A = 8'h61;
	localparam logic [7:0] ASCII_LOWER_Z = 8'h7A;
	localparam logic [7:0] ASCII_CASE    = 8'h20;

	// PLACE uses a (letter) and sq_pos; PAIR uses a, b and last.
	typedef struct packed {
		logic    kind;
		letter_t a;
		letter_t b;
		cell_t   sq_pos;
		logic    last;
	} cmd_t;

	typedef struct packed {
		logic    is_letter;
		letter_t idx;
	} folded_t;

	function automatic folded_t fold_letter(input logic [7:0] raw);
		logic [7:0] b;
		folded_t    f;
		b = raw;
		if (b >= ASCII_LOWER_A && b <= ASCII_LOWER_Z) begin
			b = b - ASCII_CASE;
		end
		f.is_letter = (b >= ASCII_UPPER_A) && (b <= ASCII_UPPER_Z);
		f.idx       = letter_t'(b - ASCII_UPPER_A);
		if (f.idx == IDX_J) begin
			f.idx = IDX_I;
		end
		return f;
	endfunction

	// Row of a cell by comparison against the start of each row.
	function automatic coord_t cell_row(input cell_t pos);
		coord_t r;
		r = '0;
		for (int k = 1; k < SQUARE_SIDE; k++) begin
			if (pos >= cell_t'(k * SQUARE_SIDE)) begin
				r = coord_t'(k);
			end
		end
		return r;
	endfunction

	function automatic coord_t cell_col(input cell_t pos, input coord_t row);
		return coord_t'(pos - cell_t'(row * SQUARE_SIDE));
	endfunction

	function automatic coord_t coord_next(input coord_t v);
		return (v == coord_t'(SQUARE_SIDE - 1)) ? '0 : coord_t'(v + 1'b1);
	endfunction

	function automatic cell_t make_cell(input coord_t row, input coord_t col);
		return cell_t'(row * SQUARE_SIDE + col);
	endfunction

endpackage

// ===== rtl/core/playfair_digraph_encryptor_core.sv =====
// ----------------------------------------------------------------------------
// playfair_digraph_encryptor_core - Playfair encryptor over a 5x5 key square
// Top level: front end, command queue and back end.
// ----------------------------------------------------------------------------
// A key letter or a text letter that does not complete a digraph is taken
// while the command queue has room. Key done starts a sweep over the 26
// letters of the alphabet during which no word is accepted. Each completed
// digraph goes through the position table read, the key square read and two
// output words through a single output register; a four-entry command queue
// lets the input run ahead by up to four commands while the back end or the
// output side stalls. Key placements drain through the back end at one a
// cycle while it is not busy with a pair. The square memories need no clearing
// pass: they are read only after the sweep has written every cell.
// ----------------------------------------------------------------------------
module playfair_digraph_encryptor_core
	import plfe_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       s_tvalid,
	output logic       s_tready,
	input  logic [7:0] s_tdata,   // [7:0] letter
	input  logic [1:0] s_tuser,   // [1:0] mode
	output logic       m_tvalid,
	input  logic       m_tready,
	output logic [7:0] m_tdata,   // [6:0] cipher_letter, [7] zero
	output logic       m_tuser,   // [0] pair_second
	output logic       m_tlast    // message_last
);

	logic       push;
	cmd_t       push_cmd;
	logic       q_full;
	logic       q_pop;
	logic       q_avail;
	cmd_t       q_cmd;
	logic [6:0] out_letter;

	plfe_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.push     (push),
		.push_cmd (push_cmd),
		.q_full   (q_full)
	);

	plfe_queue u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.push_cmd (push_cmd),
		.full     (q_full),
		.pop      (q_pop),
		.avail    (q_avail),
		.pop_cmd  (q_cmd)
	);

	plfe_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.q_avail    (q_avail),
		.q_cmd      (q_cmd),
		.q_pop      (q_pop),
		.m_tvalid   (m_tvalid),
		.m_tready   (m_tready),
		.out_letter (out_letter),
		.out_second (m_tuser),
		.out_last   (m_tlast)
	);

	assign m_tdata = {1'b0, out_letter};

endmodule

// ===== rtl/core/plfe_queue.sv =====
// ----------------------------------------------------------------------------
// plfe_queue - command queue between front and back
// A small register FIFO of command words, so that either side can stall alone.
// ----------------------------------------------------------------------------
module plfe_queue
	import plfe_pkg::*;
(
	input  logic  clk,
	input  logic  arst_n,
	input  logic  push,
	input  cmd_t  push_cmd,
	output logic  full,
	input  logic  pop,
	output logic  avail,
	output cmd_t  pop_cmd
);

	cmd_t              slot_q [QUEUE_DEPTH];
	logic [QPTR_W-1:0] wr_ptr_q;
	logic [QPTR_W-1:0] rd_ptr_q;
	logic [QCNT_W-1:0] count_q;
	logic              do_push;
	logic              do_pop;

	assign full    = (count_q == QCNT_W'(QUEUE_DEPTH));
	assign avail   = (count_q != '0);
	assign pop_cmd = slot_q[rd_ptr_q];
	assign do_push = push && !full;
	assign do_pop  = pop && avail;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			unique case ({do_push, do_pop})
				2'b10:   count_q <= count_q + 1'b1;
				2'b01:   count_q <= count_q - 1'b1;
				default: count_q <= count_q;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (do_push) begin
			slot_q[wr_ptr_q] <= push_cmd;
		end
	end

	a_no_push_when_full: assert property (@(posedge clk) disable iff (!arst_n)
		!(push && full))
		else $error("command pushed into a full queue");

endmodule

// ===== rtl/core/plfe_front.sv =====
// ----------------------------------------------------------------------------
// plfe_front - input acceptance and classification
// Folds letters, builds the key order, pairs text letters into digraphs and
// issues place and pair commands. Key done starts a sweep over the alphabet.
// ----------------------------------------------------------------------------
module plfe_front
	import plfe_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       s_tvalid,
	output logic       s_tready,
	input  logic [7:0] s_tdata,
	input  logic [1:0] s_tuser,
	output logic       push,
	output cmd_t       push_cmd,
	input  logic       q_full
);

	logic [LETTERS-1:0] used_q;
	logic [FILL_W-1:0]  fill_q;
	logic               key_ready_q;
	letter_t            held_q;
	logic               held_valid_q;
	logic               sweep_q;
	letter_t            sweep_k_q;

	folded_t f;
	logic    accept;
	logic    room;
	logic    key_place;
	logic    sweep_place;
	logic    text_go;
	logic    end_go;

	assign f        = fold_letter(s_tdata);
	assign s_tready = !sweep_q && !q_full;
	assign accept   = s_tvalid && s_tready;
	assign room     = (fill_q < FILL_W'(CELLS));

	assign key_place = accept && (s_tuser == MODE_KEY) && !key_ready_q && f.is_letter
		&& !used_q[f.idx] && room;
	assign sweep_place = sweep_q && !q_full && (sweep_k_q != IDX_J)
		&& !used_q[sweep_k_q] && room;
	assign text_go = accept && (s_tuser == MODE_TEXT) && key_ready_q && f.is_letter
		&& held_valid_q;
	assign end_go  = accept && (s_tuser == MODE_END) && key_ready_q && held_valid_q;

	always_comb begin
		push            = key_place || sweep_place || text_go || end_go;
		push_cmd        = '0;
		push_cmd.sq_pos = cell_t'(fill_q);
		priority if (sweep_place) begin
			push_cmd.kind = CMD_PLACE;
			push_cmd.a    = sweep_k_q;
		end else if (key_place) begin
			push_cmd.kind = CMD_PLACE;
			push_cmd.a    = f.idx;
		end else begin
			// A doubled pair, or end of message, pairs the held letter with X.
			push_cmd.kind = CMD_PAIR;
			push_cmd.a    = held_q;
			push_cmd.b    = (end_go || held_q == f.idx) ? IDX_X : f.idx;
			push_cmd.last = end_go;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			used_q       <= '0;
			fill_q       <= '0;
			key_ready_q  <= 1'b0;
			held_q       <= '0;
			held_valid_q <= 1'b0;
			sweep_q      <= 1'b0;
			sweep_k_q    <= '0;
		end else begin
			if (key_place) begin
				used_q[f.idx] <= 1'b1;
				fill_q        <= fill_q + 1'b1;
			end
			if (sweep_place) begin
				used_q[sweep_k_q] <= 1'b1;
				fill_q            <= fill_q + 1'b1;
			end
			if (sweep_q && !q_full) begin
				sweep_k_q <= sweep_k_q + 1'b1;
				if (sweep_k_q == letter_t'(LETTERS - 1)) begin
					sweep_q <= 1'b0;
				end
			end
			if (accept) begin
				unique case (s_tuser)
					MODE_DONE: begin
						if (!key_ready_q) begin
							key_ready_q  <= 1'b1;
							sweep_q      <= 1'b1;
							sweep_k_q    <= '0;
							held_valid_q <= 1'b0;
							held_q       <= '0;
						end
					end
					MODE_TEXT: begin
						if (key_ready_q && f.is_letter) begin
							if (!held_valid_q) begin
								held_q       <= f.idx;
								held_valid_q <= 1'b1;
							end else if (held_q != f.idx) begin
								held_q       <= '0;
								held_valid_q <= 1'b0;
							end
						end
					end
					MODE_END: begin
						if (key_ready_q) begin
							held_q       <= '0;
							held_valid_q <= 1'b0;
						end
					end
					default: begin
					end
				endcase
			end
		end
	end

	a_sweep_blocks_input: assert property (@(posedge clk) disable iff (!arst_n)
		sweep_q |-> !s_tready)
		else $error("input accepted during the alphabet sweep");

	a_fill_bound: assert property (@(posedge clk) disable iff (!arst_n)
		fill_q <= FILL_W'(CELLS))
		else $error("square fill count beyond the square");

endmodule

// ===== rtl/core/plfe_back.sv =====
// ----------------------------------------------------------------------------
// plfe_back - square memories and digraph encryption
// Writes placements into the key square and the letter position table, and
// turns each pair command into two cipher words through an output register.
// ----------------------------------------------------------------------------
module plfe_back
	import plfe_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       q_avail,
	input  cmd_t       q_cmd,
	output logic       q_pop,
	output logic       m_tvalid,
	input  logic       m_tready,
	output logic [6:0] out_letter,
	output logic       out_second,
	output logic       out_last
);

	localparam logic [1:0] ST_IDLE  = 2'd0;
	localparam logic [1:0] ST_LOOK  = 2'd1;
	localparam logic [1:0] ST_EMIT0 = 2'd2;
	localparam logic [1:0] ST_EMIT1 = 2'd3;

	letter_t key_square [CELLS];
	cell_t   letter_place [LETTERS];

	logic [1:0] state_q;
	cell_t      pa_q;
	cell_t      pb_q;
	logic       last_q;
	letter_t    ka_q;
	letter_t    kb_q;
	logic       out_valid_q;
	logic [6:0] out_letter_q;
	logic       out_second_q;
	logic       out_last_q;

	coord_t ra, ca, rb, cb;
	cell_t  qa, qb;
	logic   out_free;
	logic   take_cmd;

	assign q_pop    = (state_q == ST_IDLE);
	assign take_cmd = q_pop && q_avail;
	assign out_free = !out_valid_q || m_tready;

	always_comb begin
		ra = cell_row(pa_q);
		ca = cell_col(pa_q, ra);
		rb = cell_row(pb_q);
		cb = cell_col(pb_q, rb);
		priority if (ra == rb) begin
			qa = make_cell(ra, coord_next(ca));
			qb = make_cell(rb, coord_next(cb));
		end else if (ca == cb) begin
			qa = make_cell(coord_next(ra), ca);
			qb = make_cell(coord_next(rb), cb);
		end else begin
			qa = make_cell(ra, cb);
			qb = make_cell(rb, ca);
		end
	end

	// Memories: one write per cycle, registered reads.
	always_ff @(posedge clk) begin
		if (take_cmd && q_cmd.kind == CMD_PLACE) begin
			key_square[q_cmd.sq_pos] <= q_cmd.a;
			letter_place[q_cmd.a]    <= q_cmd.sq_pos;
		end
		if (take_cmd && q_cmd.kind == CMD_PAIR) begin
			pa_q   <= letter_place[q_cmd.a];
			pb_q   <= letter_place[q_cmd.b];
			last_q <= q_cmd.last;
		end
		if (state_q == ST_LOOK) begin
			ka_q <= key_square[qa];
			kb_q <= key_square[qb];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			// A free output register either takes the next word or empties.
			if (out_free) begin
				out_valid_q <= (state_q == ST_EMIT0) || (state_q == ST_EMIT1);
			end
			unique case (state_q)
				ST_IDLE: begin
					if (take_cmd && q_cmd.kind == CMD_PAIR) begin
						state_q <= ST_LOOK;
					end
				end
				ST_LOOK: begin
					state_q <= ST_EMIT0;
				end
				ST_EMIT0: begin
					if (out_free) begin
						state_q <= ST_EMIT1;
					end
				end
				ST_EMIT1: begin
					if (out_free) begin
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (out_free && state_q == ST_EMIT0) begin
			out_letter_q <= ASCII_UPPER_A[6:0] + 7'(ka_q);
			out_second_q <= 1'b0;
			out_last_q   <= 1'b0;
		end
		if (out_free && state_q == ST_EMIT1) begin
			out_letter_q <= ASCII_UPPER_A[6:0] + 7'(kb_q);
			out_second_q <= 1'b1;
			out_last_q   <= last_q;
		end
	end

	assign m_tvalid   = out_valid_q;
	assign out_letter = out_letter_q;
	assign out_second = out_second_q;
	assign out_last   = out_last_q;

	a_look_after_pop: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_LOOK) |-> ($past(state_q) == ST_IDLE))
		else $error("square lookup without a popped pair command");

	a_last_on_second: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && out_last_q) |-> out_second_q)
		else $error("message end flagged on a first digraph letter");

endmodule

// ===== verif/testbench.sv =====
// ----------------------------------------------------------------------------
// testbench - self-checking bench for playfair_digraph_encryptor_core
// Builds a key square from directed key words, then drives directed and
// random plaintext through the stream input. A predictor keeps its own key
// square and digraph state and queues the cipher words each accepted input
// word should produce. Every output word is checked against them in order.
// Both sides idle in random bursts. One long output stall fills the block.
// ----------------------------------------------------------------------------
module testbench;

	timeunit 1ns;
	timeprecision 1ps;

	import plfe_pkg::*;

	localparam int CYCLE_LIMIT = 200000;
	localparam int TAIL_CYCLES = 16;

	typedef struct packed {
		logic [6:0] cipher;
		logic       second;
		logic       last;
	} cipher_word_t;

	logic       clk      = 1'b0;
	logic       arst_n   = 1'b0;
	logic       s_tvalid = 1'b0;
	logic       s_tready;
	logic [7:0] s_tdata  = 8'h00;   // [7:0] letter
	logic [1:0] s_tuser  = MODE_KEY; // [1:0] mode
	logic       m_tvalid;
	logic       m_tready = 1'b0;
	logic [7:0] m_tdata;            // [6:0] cipher_letter, [7] zero
	logic       m_tuser;            // [0] pair_second
	logic       m_tlast;            // message_last

	playfair_digraph_encryptor_core dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser),
		.m_tlast  (m_tlast)
	);

	// Predicted key square and digraph state.
	letter_t      sq_letter [CELLS];
	cell_t        place_of [LETTERS];
	logic [25:0]  seen_mask    = '0;
	int           fill_count   = 0;
	letter_t      held_idx     = '0;
	logic         holding      = 1'b0;
	logic         square_ready = 1'b0;

	cipher_word_t expected_words [$];
	cipher_word_t front_word;

	int  error_count   = 0;
	int  words_sent    = 0;
	int  live_words    = 0;
	int  words_checked = 0;
	int  digraph_count = 0;
	int  pad_count     = 0;
	int  cycle_count   = 0;
	int  long_hold     = 0;
	int  rx_stall_left = 0;
	bit  sender_idling   = 1'b1;
	bit  receiver_idling = 1'b1;
	logic [7:0] last_letter = "A";

	initial begin
		forever #10 clk = ~clk;
	end

	initial begin
		while (cycle_count < CYCLE_LIMIT) begin
			@(posedge clk);
			cycle_count++;
		end
		$display("%0t: run exceeded %0d cycles", $time, CYCLE_LIMIT);
		$display("** playfair_digraph_encryptor_core: FAILED **");
		$finish;
	end

	// ------------------------------------------------------------------------
	// Predictor
	// ------------------------------------------------------------------------
	function automatic logic to_index(input logic [7:0] raw, output letter_t idx);
		logic [7:0] up;
		up = (raw >= ASCII_LOWER_A && raw <= ASCII_LOWER_Z) ? raw - ASCII_CASE : raw;
		idx = letter_t'(up - ASCII_UPPER_A);
		if (idx == IDX_J) begin
			idx = IDX_I;
		end
		return (up >= ASCII_UPPER_A) && (up <= ASCII_UPPER_Z);
	endfunction

	function automatic void add_to_square(input letter_t l);
		if (fill_count < CELLS && !seen_mask[l]) begin
			sq_letter[fill_count] = l;
			place_of[l]           = cell_t'(fill_count);
			seen_mask[l]          = 1'b1;
			fill_count++;
		end
	endfunction

	function automatic void queue_digraph(input letter_t a, input letter_t b, input logic last);
		int pa, pb, ra, ca, rb, cb, qa, qb;
		pa = place_of[a];
		pb = place_of[b];
		ra = pa / SQUARE_SIDE;
		ca = pa % SQUARE_SIDE;
		rb = pb / SQUARE_SIDE;
		cb = pb % SQUARE_SIDE;
		if (ra == rb) begin
			qa = ra * SQUARE_SIDE + (ca + 1) % SQUARE_SIDE;
			qb = rb * SQUARE_SIDE + (cb + 1) % SQUARE_SIDE;
		end else if (ca == cb) begin
			qa = ((ra + 1) % SQUARE_SIDE) * SQUARE_SIDE + ca;
			qb = ((rb + 1) % SQUARE_SIDE) * SQUARE_SIDE + cb;
		end else begin
			qa = ra * SQUARE_SIDE + cb;
			qb = rb * SQUARE_SIDE + ca;
		end
		expected_words.push_back('{cipher: 7'(ASCII_UPPER_A + sq_letter[qa]),
			second: 1'b0, last: 1'b0});
		expected_words.push_back('{cipher: 7'(ASCII_UPPER_A + sq_letter[qb]),
			second: 1'b1, last: last});
		digraph_count++;
		if (last) begin
			pad_count++;
		end
	endfunction

	// Returns 1 on a key letter before key done or a word with effect.
	function automatic bit apply_word(input logic [1:0] mode, input logic [7:0] raw);
		letter_t l;
		logic    is_letter;
		is_letter = to_index(raw, l);
		case (mode)
			MODE_KEY: begin
				if (square_ready || !is_letter) begin
					return 1'b0;
				end
				add_to_square(l);
			end
			MODE_DONE: begin
				if (square_ready) begin
					return 1'b0;
				end
				for (int k = 0; k < LETTERS; k++) begin
					if (letter_t'(k) != IDX_J) begin
						add_to_square(letter_t'(k));
					end
				end
				square_ready = 1'b1;
				holding      = 1'b0;
				held_idx     = '0;
			end
			MODE_TEXT: begin
				if (!square_ready || !is_letter) begin
					return 1'b0;
				end
				if (!holding) begin
					held_idx = l;
					holding  = 1'b1;
				end else if (held_idx == l) begin
					// A doubled letter is split by X and stays held.
					queue_digraph(held_idx, IDX_X, 1'b0);
				end else begin
					queue_digraph(held_idx, l, 1'b0);
					holding  = 1'b0;
					held_idx = '0;
				end
			end
			default: begin
				if (!square_ready || !holding) begin
					return 1'b0;
				end
				queue_digraph(held_idx, IDX_X, 1'b1);
				holding  = 1'b0;
				held_idx = '0;
			end
		endcase
		return 1'b1;
	endfunction

	// ------------------------------------------------------------------------
	// Input side
	// ------------------------------------------------------------------------
	task automatic send_word(input logic [1:0] mode, input logic [7:0] letter);
		int gap;
		if (sender_idling && $urandom_range(0, 3) == 0) begin
			gap = $urandom_range(1, 11);
			s_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser  <= mode;
		s_tdata  <= letter;
		do @(posedge clk); while (!s_tready);
		words_sent++;
		if (apply_word(mode, letter)) begin
			live_words++;
		end
	endtask

	task automatic stop_sending();
		s_tvalid <= 1'b0;
	endtask

	function automatic logic [7:0] random_letter();
		logic [7:0] b;
		if ($urandom_range(0, 6) == 0) begin
			b = last_letter;
		end else begin
			b = ASCII_UPPER_A + 8'($urandom_range(0, 25));
			if ($urandom_range(0, 1) == 1) begin
				b = b + ASCII_CASE;
			end
		end
		last_letter = b;
		return b;
	endfunction

	// Mostly plaintext letters, some message ends, and some arbitrary words.
	task automatic send_random_words(input int count);
		int    target;
		int    pick;
		target = words_sent + count;
		while (words_sent < target) begin
			pick = $urandom_range(0, 99);
			if (pick < 80) begin
				send_word(MODE_TEXT, random_letter());
			end else if (pick < 88) begin
				send_word(MODE_END, 8'($urandom_range(0, 255)));
			end else begin
				send_word(2'($urandom_range(0, 3)), 8'($urandom_range(0, 255)));
			end
		end
	endtask

	// ------------------------------------------------------------------------
	// Output side
	// ------------------------------------------------------------------------
	always @(posedge clk) begin
		if (long_hold > 0) begin
			m_tready <= 1'b0;
			long_hold--;
		end else if (rx_stall_left > 0) begin
			m_tready <= 1'b0;
			rx_stall_left--;
		end else if (receiver_idling && $urandom_range(0, 5) == 0) begin
			m_tready      <= 1'b0;
			rx_stall_left = $urandom_range(1, 11) - 1;
		end else begin
			m_tready <= 1'b1;
		end
	end

	always @(posedge clk) begin
		if (arst_n && m_tvalid && m_tready) begin
			if (expected_words.size() == 0) begin
				error_count++;
				$display("%0t: unexpected word: expected none, actual tdata=%h tuser=%b tlast=%b",
					$time, m_tdata, m_tuser, m_tlast);
			end else begin
				front_word = expected_words.pop_front();
				words_checked++;
				if (m_tdata !== {1'b0, front_word.cipher}) begin
					error_count++;
					$display("%0t: cipher_letter: expected %h actual %h",
						$time, {1'b0, front_word.cipher}, m_tdata);
				end
				if (m_tuser !== front_word.second) begin
					error_count++;
					$display("%0t: pair_second: expected %b actual %b",
						$time, front_word.second, m_tuser);
				end
				if (m_tlast !== front_word.last) begin
					error_count++;
					$display("%0t: message_last: expected %b actual %b",
						$time, front_word.last, m_tlast);
				end
			end
		end
	end

	// ------------------------------------------------------------------------
	// Tests
	// ------------------------------------------------------------------------
	task automatic test_text_before_key();
		send_word(MODE_TEXT, "A");
		send_word(MODE_END, "A");
	endtask

	// Key "Play Jiz" with a space, a 0xFF byte, a folded J and repeats.
	task automatic test_key_square();
		send_word(MODE_KEY, "P");
		send_word(MODE_KEY, "l");
		send_word(MODE_KEY, "a");
		send_word(MODE_KEY, "y");
		send_word(MODE_KEY, " ");
		send_word(MODE_KEY, "J");
		send_word(MODE_KEY, "i");
		send_word(MODE_KEY, 8'hFF);
		send_word(MODE_KEY, "z");
		send_word(MODE_DONE, 8'h00);
		send_word(MODE_DONE, 8'hFF);
		send_word(MODE_KEY, "Q");
	endtask

	task automatic test_digraph_rules();
		send_word(MODE_TEXT, "P");  // same row
		send_word(MODE_TEXT, "A");
		send_word(MODE_TEXT, "Z");  // rectangle
		send_word(MODE_TEXT, "h");
		send_word(MODE_TEXT, "E");  // doubled letter, then same column with X
		send_word(MODE_TEXT, "e");
		send_word(MODE_TEXT, "x");
		send_word(MODE_TEXT, "x");  // doubled X
		send_word(MODE_TEXT, "X");
		send_word(MODE_TEXT, "5");
	endtask

	task automatic test_message_end();
		send_word(MODE_END, 8'h00);  // pads the held X
		send_word(MODE_END, 8'h00);  // nothing held
		send_word(MODE_TEXT, "j");
		send_word(MODE_END, "q");
	endtask

	task automatic test_random_text(input int count);
		int chunk;
		while (count > 0) begin
			chunk = (count > 60) ? 60 : count;
			sender_idling   = ($urandom_range(0, 3) != 0);
			receiver_idling = ($urandom_range(0, 3) != 0);
			send_random_words(chunk);
			count -= chunk;
		end
		sender_idling   = 1'b1;
		receiver_idling = 1'b1;
	endtask

	// The output stalls for a long stretch while plaintext keeps coming,
	// so the command queue fills and the input is held off.
	task automatic test_output_stall();
		sender_idling = 1'b0;
		long_hold     = 300;
		for (int k = 0; k < 40; k++) begin
			send_word(MODE_TEXT, random_letter());
		end
		sender_idling = 1'b1;
	endtask

	task automatic test_quiet_tail(input int count);
		sender_idling   = 1'b0;
		receiver_idling = 1'b0;
		send_random_words(count);
		send_word(MODE_END, 8'h00);
	endtask

	task automatic wait_for_drain();
		stop_sending();
		while (expected_words.size() != 0) begin
			@(posedge clk);
		end
		repeat (TAIL_CYCLES) @(posedge clk);
	endtask

	initial begin
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_text_before_key();
		test_key_square();
		test_digraph_rules();
		test_message_end();
		test_random_text(480);
		test_output_stall();
		test_random_text(40);
		test_quiet_tail(90);
		wait_for_drain();

		$display("Sent %0d words (%0d with effect); %0d digraphs, %0d padded at message end.",
			words_sent, live_words, digraph_count, pad_count);
		$display("Checked %0d cipher words, including one long output stall.", words_checked);
		if (error_count == 0) begin
			$display("** playfair_digraph_encryptor_core: PASSED **");
		end else begin
			$display("** playfair_digraph_encryptor_core: FAILED **");
		end
		$finish;
	end

endmodule

// ===== sim.f =====
rtl/core/plfe_pkg.sv
rtl/core/plfe_queue.sv
rtl/core/plfe_front.sv
rtl/core/plfe_back.sv
rtl/core/playfair_digraph_encryptor_core.sv
verif/testbench.sv
